[rtl/core/nearest_neighbor_image_scaler_assert.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define NNIS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define NNIS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/core/nnis_pkg.sv]
// package for the nearest neighbour image scaler
// holds frame sizes, field widths and the action codes; no dependencies
package nnis_pkg;
   localparam int MaxWidth   = 256;
   localparam int MaxHeight  = 256;
   localparam int MaxDstDim  = 4096;
   localparam int ColW       = $clog2(MaxWidth);
   localparam int RowW       = $clog2(MaxHeight);
   localparam int AddrW      = ColW + RowW;
   localparam int FrameWords = MaxWidth * MaxHeight;
   localparam int PixW       = 32;
   localparam int SrcW       = 9;
   localparam int DstW       = 13;
   localparam int CoordW     = 12;
   localparam int ProdW      = CoordW + SrcW;
   localparam int QuotW      = ProdW;

   typedef enum logic [0:0] {
      ACT_WRITE   = 1'b0,
      ACT_REQUEST = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      REG_SRC_WIDTH  = 2'd0,
      REG_SRC_HEIGHT = 2'd1,
      REG_DST_WIDTH  = 2'd2,
      REG_DST_HEIGHT = 2'd3
   } reg_index_type;

   // clamp a size register value into 1..maxv
   function automatic logic [DstW-1:0] clamp_size(input logic [DstW-1:0] v,
                                                  input logic [DstW:0] maxv);
      logic [DstW-1:0] r;
      if (v == '0) r = DstW'(1);
      else if ({1'b0, v} > maxv) r = maxv[DstW-1:0];
      else r = v;
      return r;
   endfunction
endpackage

[rtl/core/nearest_neighbor_image_scaler.sv]
// nearest neighbour image scaler, top level
// depends on nnis_pkg, nnis_div and nnis_ram
//
// channels: req_ takes items (write a source pixel or request a destination
// pixel), rsp_ returns one item per request and none per write; csr_ writes
// the four size registers, which the user must write only while the block
// is idle; the block does not enforce this. throughput: one item per cycle
// while rsp_ is not stalled. the pipeline advances whenever its last stage
// is empty or the result is taken; a stall on rsp_ holds the whole pipeline
// and raises req_stall. path: a request passes the multiply stage (loaded
// at the accepting edge), QuotW divider stages, the ram read and the output
// register before it reaches rsp_valid. writes go to the frame ram when they
// leave the divider stages, in item order with the reads, so a read always
// sees earlier writes.
// reset clears pipeline valids and sets the sizes to 256; the frame ram is
// not cleared and a pixel must be written before it is requested.
module nearest_neighbor_image_scaler
   import nnis_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_action,
   input  logic [CoordW-1:0] req_col,
   input  logic [CoordW-1:0] req_row,
   input  logic [PixW-1:0]   req_pixel_in,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PixW-1:0]   rsp_pixel_out,
   output logic              rsp_in_range,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [DstW-1:0]   csr_wr_data
);
   localparam int Lat = QuotW + 1;   // multiply stage plus divider stages

   logic [SrcW-1:0] src_w_ff, src_h_ff;
   logic [DstW-1:0] dst_w_ff, dst_h_ff;

   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= SrcW'(256);
         src_h_ff <= SrcW'(256);
         dst_w_ff <= DstW'(256);
         dst_h_ff <= DstW'(256);
      end else if (csr_wr_en) begin
         unique case (reg_index_type'(csr_index))
            REG_SRC_WIDTH:  src_w_ff <= SrcW'(clamp_size({4'b0, csr_wr_data[SrcW-1:0]},
                                                     (DstW+1)'(MaxWidth)));
            REG_SRC_HEIGHT: src_h_ff <= SrcW'(clamp_size({4'b0, csr_wr_data[SrcW-1:0]},
                                                     (DstW+1)'(MaxHeight)));
            REG_DST_WIDTH:  dst_w_ff <= clamp_size(csr_wr_data, (DstW+1)'(MaxDstDim));
            REG_DST_HEIGHT: dst_h_ff <= clamp_size(csr_wr_data, (DstW+1)'(MaxDstDim));
            default: ;
         endcase
      end
   end

   // pipeline advance: held only when a result waits and is stalled
   logic adv;
   logic out_valid_ff;
   assign adv       = !(out_valid_ff && rsp_stall);
   assign req_stall = !adv;

   logic req_acc;
   assign req_acc = req_valid && adv;

   // side-band pipe alongside the multiply and divider stages
   logic              v_ff   [Lat];
   logic              act_ff [Lat];
   logic              ok_ff  [Lat];
   logic [CoordW-1:0] col_ff [Lat];
   logic [CoordW-1:0] row_ff [Lat];
   logic [PixW-1:0]   pix_ff [Lat];
   logic [ProdW-1:0]  px_ff, py_ff;

   // entry stage: range checks and the products
   logic ok_in;
   always_comb begin
      if (req_action == ACT_WRITE)
         ok_in = ({1'b0, req_col} < {4'b0, src_w_ff}) &&
                 ({1'b0, req_row} < {4'b0, src_h_ff});
      else
         ok_in = ({1'b0, req_col} < dst_w_ff) && ({1'b0, req_row} < dst_h_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Lat; i++) v_ff[i] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= req_acc;
         for (int i = 1; i < Lat; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         act_ff[0] <= req_action;
         ok_ff[0]  <= ok_in;
         col_ff[0] <= req_col;
         row_ff[0] <= req_row;
         pix_ff[0] <= req_pixel_in;
         px_ff     <= req_col * src_w_ff;
         py_ff     <= req_row * src_h_ff;
         for (int i = 1; i < Lat; i++) begin
            act_ff[i] <= act_ff[i-1];
            ok_ff[i]  <= ok_ff[i-1];
            col_ff[i] <= col_ff[i-1];
            row_ff[i] <= row_ff[i-1];
            pix_ff[i] <= pix_ff[i-1];
         end
      end
   end

   // pipelined dividers for the two source coordinates
   logic [QuotW-1:0] sx, sy;
   nnis_div u_div_x (.clock, .en(adv), .dividend(px_ff), .divisor(dst_w_ff),
                     .quotient(sx));
   nnis_div u_div_y (.clock, .en(adv), .dividend(py_ff), .divisor(dst_h_ff),
                     .quotient(sy));

   // frame access: writes and reads share the ram in item order
   localparam int L = Lat - 1;
   logic             is_wr, is_rd;
   logic [AddrW-1:0] wr_addr, rd_addr;
   assign is_wr   = v_ff[L] && act_ff[L] == ACT_WRITE && ok_ff[L];
   assign is_rd   = v_ff[L] && act_ff[L] == ACT_REQUEST && ok_ff[L];
   assign wr_addr = {row_ff[L][RowW-1:0], col_ff[L][ColW-1:0]};
   assign rd_addr = {sy[RowW-1:0], sx[ColW-1:0]};

   logic [PixW-1:0] rd_data;
   nnis_ram #(.Width(PixW), .Depth(FrameWords)) u_frame (
      .clock, .wr_en(is_wr && adv), .wr_addr, .wr_data(pix_ff[L]),
      .rd_en(is_rd && adv), .rd_addr, .rd_data);

   // ram read stage then output register
   logic rv_ff, rok_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         rv_ff        <= v_ff[L] && act_ff[L] == ACT_REQUEST;
         out_valid_ff <= rv_ff;
      end
   end

   logic [PixW-1:0] out_pix_ff;
   logic            out_ok_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         rok_ff     <= ok_ff[L];
         out_ok_ff  <= rok_ff;
         out_pix_ff <= rok_ff ? rd_data : '0;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_out = out_pix_ff;
   assign rsp_in_range  = out_ok_ff;
endmodule

[rtl/core/nnis_ram.sv]
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module nnis_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

[rtl/core/nnis_div.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on nnis_pkg
module nnis_div
   import nnis_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [ProdW-1:0] dividend,
   input  logic [DstW-1:0]  divisor,
   output logic [QuotW-1:0] quotient
);
   logic [ProdW-1:0] rem_ff [QuotW];
   logic [ProdW-1:0] quo_ff [QuotW];
   logic [DstW-1:0]  dvs_ff [QuotW];

   // one stage per quotient bit, most significant first
   for (genvar s = 0; s < QuotW; s++) begin : g_stage
      logic [ProdW-1:0] rem_cur;
      logic [ProdW-1:0] quo_cur;
      logic [DstW-1:0]  dvs_cur;
      logic [ProdW:0]   trial;
      logic [ProdW:0]   diff;
      if (s == 0) begin : g_first
         assign rem_cur = '0;
         assign quo_cur = dividend;
         assign dvs_cur = divisor;
      end else begin : g_next
         assign rem_cur = rem_ff[s-1];
         assign quo_cur = quo_ff[s-1];
         assign dvs_cur = dvs_ff[s-1];
      end
      always_comb begin
         trial = {rem_cur, quo_cur[ProdW-1]};
         diff  = trial - {{(ProdW+1-DstW){1'b0}}, dvs_cur};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (!diff[ProdW]) begin
               rem_ff[s] <= diff[ProdW-1:0];
               quo_ff[s] <= {quo_cur[ProdW-2:0], 1'b1};
            end else begin
               rem_ff[s] <= trial[ProdW-1:0];
               quo_ff[s] <= {quo_cur[ProdW-2:0], 1'b0};
            end
            dvs_ff[s] <= dvs_cur;
         end
      end
   end
   assign quotient = quo_ff[QuotW-1];
endmodule

[rtl/core/nnis_checker.sv]
// port-level checker for the scaler, bound to the top level
// depends on nnis_pkg and nearest_neighbor_image_scaler_assert.svh
`include "nearest_neighbor_image_scaler_assert.svh"
module nnis_checker
   import nnis_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [PixW-1:0]   rsp_pixel_out,
   input logic              rsp_in_range
);
   // out of range answers carry a zero pixel
   `NNIS_ASSERT_IMPL(a_zero_out, clock, reset, rsp_valid && !rsp_in_range, rsp_pixel_out == '0)
   // input only stalls while a result is held back
   `NNIS_ASSERT_IMPL(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   // a stalled result stays
   `NNIS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pixel_out))
   // after reset no result is shown
   `NNIS_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)
endmodule

bind nearest_neighbor_image_scaler nnis_checker u_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_pixel_out, .rsp_in_range);
